@@ hw/rtl/smsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants, state type and interface structs for the mean/stddev block.
package smsd_pkg;

    localparam int IN_BITS     = 24;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_DRAWS   = 65536;

    localparam int COUNT_BITS = 17;
    localparam int SUM_BITS   = 40;
    localparam int SQ_BITS    = 64;
    localparam int NUM_BITS   = 80;
    localparam int DEN_BITS   = 32;
    localparam int MEAN_BITS  = 24;
    localparam int SD_BITS    = 23;
    localparam int ROOT_BITS  = 2 * SD_BITS;
    localparam int CNT_BITS   = $clog2(NUM_BITS + 1);

    localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_DRAWS);
    localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(2);
    localparam logic [SD_BITS-1:0]    SD_MAX    = '1;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_MUL_NQ,
        FS_MUL_SS,
        FS_SUB,
        FS_DIV,
        FS_ROOT_CHK,
        FS_SQRT,
        FS_MEAN,
        FS_DONE
    } fin_state_t;

    typedef struct packed {
        logic                        start;
        logic signed [SUM_BITS-1:0]  sum;
        logic [SQ_BITS-1:0]          sumsq;
        logic [COUNT_BITS-1:0]       count;
    } row_t;

    typedef struct packed {
        logic                 valid;
        logic [MEAN_BITS-1:0] mean;
        logic [SD_BITS-1:0]   stddev;
        logic                 too_few;
    } result_t;

endpackage

@@ hw/rtl/smsd_accum.sv @@
`timescale 1ns / 1ps
// Running sum, sum of squares and draw count, cleared when a row closes.
module smsd_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          draw_en,
    input  logic [smsd_pkg::IN_BITS-1:0]  sample,
    input  logic                          last,
    output smsd_pkg::row_t                row
);
    import smsd_pkg::*;

    logic signed [SUM_BITS-1:0]      sum_reg, sum_next, sum_upd;
    logic [SQ_BITS-1:0]              sq_reg, sq_next, sq_upd;
    logic [COUNT_BITS-1:0]           count_reg, count_next, count_upd;
    logic signed [SAMPLE_BITS-1:0]   samp_low;
    logic signed [2*SAMPLE_BITS-1:0] square;

    always_comb begin
        samp_low = sample[SAMPLE_BITS-1:0];
        square   = samp_low * samp_low;
        // Draws past the row limit are dropped but a flagged one still closes the row.
        if (count_reg < MAX_COUNT) begin
            sum_upd   = sum_reg + SUM_BITS'(samp_low);
            sq_upd    = sq_reg + SQ_BITS'(unsigned'(square));
            count_upd = count_reg + 1'b1;
        end else begin
            sum_upd   = sum_reg;
            sq_upd    = sq_reg;
            count_upd = count_reg;
        end

        row.start = draw_en && last;
        row.sum   = sum_upd;
        row.sumsq = sq_upd;
        row.count = count_upd;

        if (draw_en && last) begin
            sum_next   = '0;
            sq_next    = '0;
            count_next = '0;
        end else if (draw_en) begin
            sum_next   = sum_upd;
            sq_next    = sq_upd;
            count_next = count_upd;
        end else begin
            sum_next   = sum_reg;
            sq_next    = sq_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            sq_reg    <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            count_reg <= count_next;
        end
    end

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT)
        else $error("draw count ran past the row limit");

endmodule

@@ hw/rtl/smsd_finish.sv @@
`timescale 1ns / 1ps
// Row finisher: sequencer around one shared add/subtract unit for mean, variance and root.
module smsd_finish (
    input  logic              aclk,
    input  logic              aresetn,
    input  smsd_pkg::row_t    row,
    input  logic              take,
    output logic              idle,
    output smsd_pkg::result_t res
);
    import smsd_pkg::*;

    fin_state_t state_reg, state_next;

    logic [CNT_BITS-1:0]     cnt_reg;
    logic [NUM_BITS-1:0]     num_reg, work_reg, quo_reg;
    logic [DEN_BITS-1:0]     den_reg;
    logic [COUNT_BITS-1:0]   n_reg;
    logic [SQ_BITS-1:0]      sumsq_reg;
    logic [SUM_BITS-1:0]     smag_reg, row_mag;
    logic                    neg_reg, too_few_reg;
    logic [SD_BITS-1:0]      sd_reg;
    logic [2*COUNT_BITS-1:0] den_full;

    logic [NUM_BITS-1:0]     alu_a, alu_b, rem_next;
    logic                    alu_sub, borrow, last_iter, root_sat;
    logic [NUM_BITS:0]       alu_res;
    logic [MEAN_BITS-1:0]    q_mean;

    // Shared unit, the values derived from it, and the divisor and magnitude terms.
    assign alu_res   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                               : ({1'b0, alu_a} + {1'b0, alu_b});
    assign borrow    = alu_sub & alu_res[NUM_BITS];
    assign rem_next  = borrow ? alu_a : alu_res[NUM_BITS-1:0];
    assign last_iter = (cnt_reg == CNT_BITS'(1));
    assign root_sat  = |quo_reg[NUM_BITS-1:ROOT_BITS];
    assign den_full  = n_reg * (n_reg - 1'b1);
    assign row_mag   = row.sum[SUM_BITS-1] ? unsigned'(-row.sum) : unsigned'(row.sum);
    assign q_mean    = quo_reg[MEAN_BITS-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (row.start) begin
                    state_next = (row.count < MIN_COUNT) ? FS_DONE : FS_MUL_NQ;
                end
            end
            FS_MUL_NQ:   if (last_iter) state_next = FS_MUL_SS;
            FS_MUL_SS:   if (last_iter) state_next = FS_SUB;
            FS_SUB:      state_next = FS_DIV;
            FS_DIV:      if (last_iter) state_next = FS_ROOT_CHK;
            FS_ROOT_CHK: state_next = root_sat ? FS_MEAN : FS_SQRT;
            FS_SQRT:     if (last_iter) state_next = FS_MEAN;
            FS_MEAN:     if (last_iter) state_next = FS_DONE;
            FS_DONE:     if (take) state_next = FS_IDLE;
            default:     state_next = FS_IDLE;
        endcase
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            FS_MUL_NQ: begin
                alu_a   = {work_reg[NUM_BITS-2:0], 1'b0};
                alu_b   = quo_reg[COUNT_BITS-1] ? NUM_BITS'(sumsq_reg) : '0;
                alu_sub = 1'b0;
            end
            FS_MUL_SS: begin
                alu_a   = {work_reg[NUM_BITS-2:0], 1'b0};
                alu_b   = quo_reg[SUM_BITS-1] ? NUM_BITS'(smag_reg) : '0;
                alu_sub = 1'b0;
            end
            FS_SUB: begin
                alu_a = num_reg;
                alu_b = work_reg;
            end
            FS_DIV: begin
                alu_a = NUM_BITS'({work_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]});
                alu_b = NUM_BITS'(den_reg);
            end
            FS_SQRT: begin
                alu_a = {work_reg[NUM_BITS-3:0], num_reg[ROOT_BITS-1 -: 2]};
                alu_b = NUM_BITS'({quo_reg[SD_BITS-1:0], 2'b01});
            end
            FS_MEAN: begin
                alu_a = NUM_BITS'({work_reg[COUNT_BITS-1:0], num_reg[SUM_BITS-1]});
                alu_b = NUM_BITS'(n_reg);
            end
            default: ;
        endcase

        idle          = (state_reg == FS_IDLE);
        res.valid     = (state_reg == FS_DONE);
        res.too_few   = too_few_reg;
        res.mean      = too_few_reg ? '0 : (neg_reg ? (~q_mean + 1'b1) : q_mean);
        res.stddev    = too_few_reg ? '0 : sd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            FS_IDLE: begin
                if (row.start) begin
                    n_reg       <= row.count;
                    sumsq_reg   <= row.sumsq;
                    smag_reg    <= row_mag;
                    neg_reg     <= row.sum[SUM_BITS-1];
                    too_few_reg <= (row.count < MIN_COUNT);
                    work_reg    <= '0;
                    quo_reg     <= NUM_BITS'(row.count);
                    cnt_reg     <= CNT_BITS'(COUNT_BITS);
                end
            end
            FS_MUL_NQ: begin
                den_reg  <= den_full[DEN_BITS-1:0];
                work_reg <= alu_res[NUM_BITS-1:0];
                quo_reg  <= {quo_reg[NUM_BITS-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_iter) begin
                    num_reg  <= alu_res[NUM_BITS-1:0];
                    work_reg <= '0;
                    quo_reg  <= NUM_BITS'(smag_reg);
                    cnt_reg  <= CNT_BITS'(SUM_BITS);
                end
            end
            FS_MUL_SS: begin
                work_reg <= alu_res[NUM_BITS-1:0];
                quo_reg  <= {quo_reg[NUM_BITS-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_iter) begin
                    quo_reg <= '0;
                    cnt_reg <= CNT_BITS'(NUM_BITS);
                end
            end
            FS_SUB: begin
                num_reg  <= borrow ? '0 : alu_res[NUM_BITS-1:0];
                work_reg <= '0;
                quo_reg  <= '0;
            end
            FS_DIV: begin
                num_reg  <= {num_reg[NUM_BITS-2:0], 1'b0};
                work_reg <= rem_next;
                quo_reg  <= {quo_reg[NUM_BITS-2:0], ~borrow};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            FS_ROOT_CHK: begin
                work_reg <= '0;
                quo_reg  <= '0;
                if (root_sat) begin
                    sd_reg  <= SD_MAX;
                    num_reg <= NUM_BITS'(smag_reg);
                    cnt_reg <= CNT_BITS'(SUM_BITS);
                end else begin
                    num_reg <= NUM_BITS'(quo_reg[ROOT_BITS-1:0]);
                    cnt_reg <= CNT_BITS'(SD_BITS);
                end
            end
            FS_SQRT: begin
                num_reg  <= {num_reg[NUM_BITS-3:0], 2'b00};
                work_reg <= rem_next;
                quo_reg  <= {quo_reg[NUM_BITS-2:0], ~borrow};
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_iter) begin
                    sd_reg   <= {quo_reg[SD_BITS-2:0], ~borrow};
                    num_reg  <= NUM_BITS'(smag_reg);
                    work_reg <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= CNT_BITS'(SUM_BITS);
                end
            end
            FS_MEAN: begin
                num_reg  <= {num_reg[NUM_BITS-2:0], 1'b0};
                work_reg <= rem_next;
                quo_reg  <= {quo_reg[NUM_BITS-2:0], ~borrow};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        row.start |-> (state_reg == FS_IDLE))
        else $error("row closed while the finisher was busy");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FS_DIV) |-> (work_reg < NUM_BITS'(den_reg)))
        else $error("variance divide remainder not below divisor");

    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FS_SQRT) |-> (work_reg <= {quo_reg[NUM_BITS-2:0], 1'b0}))
        else $error("root remainder above twice the partial root");

    a_mean_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FS_MEAN) |-> (work_reg < NUM_BITS'(n_reg)))
        else $error("mean divide remainder not below draw count");

endmodule

@@ hw/rtl/sample_mean_stddev.sv @@
`timescale 1ns / 1ps
// Top level of the streaming sample mean and standard deviation block.
//
// The block takes signed Q8.16 draws on the s_ channel, the last draw of a row
// marked by s_last, and keeps an exact running sum, sum of squares and count.
// Draws that do not close a row are taken one per clock while the finisher is
// idle. When the flagged draw is taken, the row's totals are handed to a
// finisher that runs the final arithmetic through one shared 80-bit add/subtract
// unit, the divisor n*(n-1) coming from a separate multiplier: a shift-add
// multiply of count by sum of squares, a shift-add square of the sum, one
// subtract, a restoring divide by n*(n-1), a range check, a bit-pair square root
// (skipped when the result saturates) and a restoring divide for the mean. A row
// that held fewer than two draws skips the arithmetic. While the finisher runs,
// and until its result moves into the output register, s_ready is low. The
// result then sits in an output register on the m_ channel; new draws are taken
// while it waits to be consumed. The mean is truncated toward zero, the standard
// deviation is the truncated root and saturates at its largest value, and a row
// with fewer than two draws gives zeros with m_too_few set. Draws past the row
// limit of 65536 are ignored, but a flagged one still closes the row.
module sample_mean_stddev (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [smsd_pkg::IN_BITS-1:0]    s_sample,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [smsd_pkg::MEAN_BITS-1:0]  m_mean,
    output logic [smsd_pkg::SD_BITS-1:0]    m_stddev,
    output logic                            m_too_few
);
    import smsd_pkg::*;

    row_t                 row;
    result_t              res;
    logic                 fin_idle;
    logic                 draw_en;
    logic                 take;
    logic                 m_valid_reg, m_valid_next;
    logic [MEAN_BITS-1:0] m_mean_reg;
    logic [SD_BITS-1:0]   m_stddev_reg;
    logic                 m_too_few_reg;

    // Draws are accepted whenever the finisher is free; a finished row blocks
    // input until its result moves into the output register.
    assign s_ready = fin_idle;
    assign draw_en = s_valid && s_ready;

    smsd_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .draw_en (draw_en),
        .sample  (s_sample),
        .last    (s_last),
        .row     (row)
    );

    smsd_finish u_finish (
        .aclk    (aclk),
        .aresetn (aresetn),
        .row     (row),
        .take    (take),
        .idle    (fin_idle),
        .res     (res)
    );

    // The output register loads the finished result when it is empty or being
    // drained in the same cycle.
    assign take         = res.valid && (!m_valid_reg || m_ready);
    assign m_valid_next = take || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_mean_reg    <= res.mean;
            m_stddev_reg  <= res.stddev;
            m_too_few_reg <= res.too_few;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_mean    = m_mean_reg;
    assign m_stddev  = m_stddev_reg;
    assign m_too_few = m_too_few_reg;

    a_close_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input still ready right after a row closed");

endmodule
